@@ hw/rtl/dkd_pkg.sv @@
`timescale 1ns / 1ps

package dkd_pkg;

    localparam int SYMBOL_COUNT = 9;
    localparam int SYM_W        = 4;
    localparam int ORDER_W      = SYM_W * SYMBOL_COUNT;
    localparam int IDX_W        = $clog2(SYMBOL_COUNT);
    localparam int PAIR_COUNT   = SYMBOL_COUNT * (SYMBOL_COUNT - 1) / 2;
    localparam int CNT_W        = $clog2(PAIR_COUNT + 1);
    localparam int DIST_W       = 6;
    localparam int LANES        = 2 * SYMBOL_COUNT;
    localparam int GROUP_SIZE   = 4;
    localparam int GROUPS       = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic [SYM_W-1:0]                  sym_t;
    typedef logic [IDX_W-1:0]                  idx_t;
    typedef logic [CNT_W-1:0]                  cnt_t;
    typedef logic [SYMBOL_COUNT-1:0][IDX_W-1:0] rank_vec_t;
    typedef logic [LANES-1:0][CNT_W-1:0]       cnt_vec_t;
    typedef logic [GROUPS-1:0][CNT_W-1:0]      grp_vec_t;

    typedef struct packed {
        logic valid;
        logic bad;
    } stage_ctl_t;

endpackage

@@ hw/rtl/dkd_pair_if.sv @@
`timescale 1ns / 1ps

interface dkd_pair_if;
    import dkd_pkg::*;

    logic               valid;
    logic               ready;
    logic [ORDER_W-1:0] first_order;
    logic [ORDER_W-1:0] second_order;

    modport source (output valid, output first_order, output second_order, input ready);
    modport sink   (input valid, input first_order, input second_order, output ready);
endinterface

@@ hw/rtl/dkd_score_if.sv @@
`timescale 1ns / 1ps

interface dkd_score_if;
    import dkd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              not_permutation;

    modport source (output valid, output distance, output not_permutation, input ready);
    modport sink   (input valid, input distance, input not_permutation, output ready);
endinterface

@@ hw/rtl/dkd_rank.sv @@
`timescale 1ns / 1ps

module dkd_rank (
    input  logic                         clk,
    input  logic                         en,
    input  logic [dkd_pkg::ORDER_W-1:0]  first_order,
    input  logic [dkd_pkg::ORDER_W-1:0]  second_order,
    output dkd_pkg::rank_vec_t           rank_reg,
    output logic                         bad
);
    import dkd_pkg::*;

    rank_vec_t                 rank_next;
    logic [SYMBOL_COUNT-1:0]   found_a;
    logic [SYMBOL_COUNT-1:0]   found_b;

    // Every symbol present among N nibbles means the word is a permutation.
    always_comb
    begin
        for (int s = 0; s < SYMBOL_COUNT; s++)
        begin
            found_a[s] = 1'b0;
            found_b[s] = 1'b0;
            for (int k = 0; k < SYMBOL_COUNT; k++)
            begin
                if (first_order[SYM_W*k +: SYM_W] == SYM_W'(s + 1))
                begin
                    found_a[s] = 1'b1;
                end
                if (second_order[SYM_W*k +: SYM_W] == SYM_W'(s + 1))
                begin
                    found_b[s] = 1'b1;
                end
            end
        end
        bad = !(&found_a) || !(&found_b);
    end

    // Position in the first ordering of each element of the second.
    always_comb
    begin
        for (int j = 0; j < SYMBOL_COUNT; j++)
        begin
            rank_next[j] = '0;
            for (int k = 0; k < SYMBOL_COUNT; k++)
            begin
                if (second_order[SYM_W*j +: SYM_W] == first_order[SYM_W*k +: SYM_W])
                begin
                    rank_next[j] = rank_next[j] | IDX_W'(k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rank_reg <= rank_next;
        end
    end

endmodule

@@ hw/rtl/dkd_lane.sv @@
`timescale 1ns / 1ps

module dkd_lane (
    input  logic               clk,
    input  logic               en,
    input  dkd_pkg::rank_vec_t rank,
    input  dkd_pkg::idx_t      shift,
    input  logic               rev,
    output dkd_pkg::cnt_t      count_reg
);
    import dkd_pkg::*;

    rank_vec_t      seq;
    cnt_t           count_next;
    logic [IDX_W:0] src;

    // Rotate, and reverse if asked, the rank sequence.
    always_comb
    begin
        src = '0;
        for (int k = 0; k < SYMBOL_COUNT; k++)
        begin
            src = (IDX_W+1)'(k) + {1'b0, shift};
            if (src >= (IDX_W+1)'(SYMBOL_COUNT))
            begin
                src = src - (IDX_W+1)'(SYMBOL_COUNT);
            end
            if (rev)
            begin
                src = (IDX_W+1)'(SYMBOL_COUNT - 1) - src;
            end
            seq[k] = rank[src[IDX_W-1:0]];
        end
    end

    // Count out-of-order pairs.
    always_comb
    begin
        count_next = '0;
        for (int i = 0; i < SYMBOL_COUNT; i++)
        begin
            for (int j = i + 1; j < SYMBOL_COUNT; j++)
            begin
                count_next = count_next + CNT_W'(seq[i] > seq[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/dkd_merge.sv @@
`timescale 1ns / 1ps

module dkd_merge (
    input  logic              clk,
    input  logic              en,
    input  dkd_pkg::cnt_vec_t counts,
    output dkd_pkg::cnt_t     best
);
    import dkd_pkg::*;

    grp_vec_t grp_next;
    grp_vec_t grp_reg;

    // First level: minimum within each group of lanes.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '1;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < LANES)
                begin
                    if (counts[g * GROUP_SIZE + j] < grp_next[g])
                    begin
                        grp_next[g] = counts[g * GROUP_SIZE + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_reg <= grp_next;
        end
    end

    // Second level: minimum over the groups.
    always_comb
    begin
        best = '1;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (grp_reg[g] < best)
            begin
                best = grp_reg[g];
            end
        end
    end

endmodule

@@ hw/rtl/dihedral_kendall_distance_unit.sv @@
`timescale 1ns / 1ps

// Minimum Kendall tau distance between a reference ordering and every rotation
// and reversed rotation of a second ordering. One pair is taken per clock while
// the output is not stalled. The pipeline has four register stages: a rank
// lookup stage, one inversion-count lane per rotation/reversal (2*SYMBOL_COUNT
// lanes running in parallel), the registered first level of a two-level minimum
// tree, and the output register. The whole pipeline advances together and
// holds while a result waits on the output side, so throughput is one pair per
// cycle whenever the consumer takes beats as they come. Inputs that are not
// permutations of 1..SYMBOL_COUNT give not_permutation set and a distance of
// zero; nibbles above the packed elements are ignored.

module dihedral_kendall_distance_unit (
    input  logic        clk,
    input  logic        rst_n,
    dkd_pair_if.sink    pair,
    dkd_score_if.source score
);
    import dkd_pkg::*;

    logic              en;
    logic              take;
    logic              bad;
    rank_vec_t         rank;
    cnt_vec_t          counts;
    cnt_t              best;

    stage_ctl_t        s1_ctl_reg;
    stage_ctl_t        s2_ctl_reg;
    stage_ctl_t        s3_ctl_reg;
    logic              score_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              np_reg;

    // Advance every stage unless a finished beat is stuck at the output.
    assign en         = !score_valid_reg || score.ready;
    assign take       = pair.valid && en;
    assign pair.ready = en;

    // Stage 1: validity check and rank of each second-ordering element.
    dkd_rank u_rank (
        .clk          (clk),
        .en           (en),
        .first_order  (pair.first_order),
        .second_order (pair.second_order),
        .rank_reg     (rank),
        .bad          (bad)
    );

    // Stage 2: one lane per rotation; the upper half works on the reversal.
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        dkd_lane u_lane (
            .clk       (clk),
            .en        (en),
            .rank      (rank),
            .shift     (IDX_W'(i % SYMBOL_COUNT)),
            .rev       (i >= SYMBOL_COUNT),
            .count_reg (counts[i])
        );
    end

    // Stage 3 and the final minimum feeding the output register.
    dkd_merge u_merge (
        .clk    (clk),
        .en     (en),
        .counts (counts),
        .best   (best)
    );

    // Control pipeline: valid and the not-a-permutation flag travel alongside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg      <= '0;
            s2_ctl_reg      <= '0;
            s3_ctl_reg      <= '0;
            score_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_ctl_reg      <= '{valid: take, bad: bad};
            s2_ctl_reg      <= s1_ctl_reg;
            s3_ctl_reg      <= s2_ctl_reg;
            score_valid_reg <= s3_ctl_reg.valid;
        end
    end

    // Output payload: drop the distance to zero for a bad pair, and keep
    // the low bits of the count otherwise.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= s3_ctl_reg.bad ? '0 : DIST_W'(best);
            np_reg   <= s3_ctl_reg.bad;
        end
    end

    assign score.valid           = score_valid_reg;
    assign score.distance        = dist_reg;
    assign score.not_permutation = np_reg;

    // A flagged result always carries a zero distance.
    a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (score.valid && score.not_permutation) |-> (score.distance == '0))
        else $error("flagged result with non-zero distance");

    // A beat in the last stage is never lost while the output stalls.
    a_hold_s3 : assert property (@(posedge clk) disable iff (!rst_n)
        (s3_ctl_reg.valid && !en) |=> s3_ctl_reg.valid)
        else $error("beat dropped from merge stage during stall");

    // A new output beat only comes from a valid merge stage.
    a_out_src : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(score_valid_reg) |-> $past(s3_ctl_reg.valid))
        else $error("output valid raised without a beat in the merge stage");

endmodule
